>>> hdl/rfpc_pkg.sv
// Shared types, sizes and index helpers for the ring FIFO with peek cursor.
// Used by rfpc_ctrl, ring_fifo_with_peek_cursor, rfpc_reply_checker and testbench; depends on nothing.
package rfpc_pkg;

    localparam int SIZE       = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int CNT_W      = $clog2(SIZE + 1);
    localparam int KIND_W     = 3;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 3'd0,
        KIND_POP   = 3'd1,
        KIND_START = 3'd2,
        KIND_FWD   = 3'd3,
        KIND_BACK  = 3'd4
    } kind_t;

    // Memory access issued for one request.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        idx_t addr;
    } mem_req_t;

    // Control fields of one result, before the read data joins them.
    typedef struct packed {
        logic ok;
        cnt_t count;
    } resp_t;

    localparam idx_t IDX_LAST = idx_t'(SIZE - 1);
    localparam cnt_t CNT_FULL = cnt_t'(SIZE);

    function automatic idx_t wrap_next(input idx_t i);
        return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t wrap_prev(input idx_t i);
        return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
    endfunction

endpackage

>>> hdl/rfpc_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module rfpc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic             rd_en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/rfpc_ctrl.sv
// Index, occupancy and cursor control for the ring FIFO.
// Decodes one request into a memory access and a result; uses rfpc_pkg.
module rfpc_ctrl
    import rfpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [KIND_W-1:0] kind,
    output mem_req_t          mem_req,
    output resp_t             resp
);

    idx_t head_reg, head_next;
    idx_t tail_reg, tail_next;
    cnt_t count_reg, count_next;
    logic cur_valid_reg, cur_valid_next;
    idx_t cur_reg, cur_next;

    logic full;
    logic empty;
    idx_t cur_fwd;
    idx_t cur_back;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign cur_fwd  = wrap_next(cur_reg);
    assign cur_back = wrap_prev(cur_reg);

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        mem_req        = '0;
        resp.ok        = 1'b0;

        case (kind)
            KIND_PUSH:
            begin
                if (!full)
                begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = head_reg;
                    head_next     = wrap_next(head_reg);
                    count_next    = cnt_t'(count_reg + 1'b1);
                    resp.ok       = 1'b1;
                end
            end
            KIND_POP:
            begin
                if (!empty)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = tail_reg;
                    tail_next     = wrap_next(tail_reg);
                    count_next    = cnt_t'(count_reg - 1'b1);
                    resp.ok       = 1'b1;
                end
            end
            KIND_START:
            begin
                if (!empty)
                begin
                    mem_req.rd_en  = 1'b1;
                    mem_req.addr   = tail_reg;
                    cur_valid_next = 1'b1;
                    cur_next       = tail_reg;
                    resp.ok        = 1'b1;
                end
            end
            KIND_FWD:
            begin
                // stop short of head
                if (cur_valid_reg && (cur_fwd != head_reg))
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = cur_fwd;
                    cur_next      = cur_fwd;
                    resp.ok       = 1'b1;
                end
            end
            KIND_BACK:
            begin
                if (cur_valid_reg && (cur_reg != tail_reg))
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = cur_back;
                    cur_next      = cur_back;
                    resp.ok       = 1'b1;
                end
            end
            default:
            begin
                resp.ok = 1'b0;
            end
        endcase

        resp.count = count_next;

        // drop the access unless the item is really taken
        if (!accept)
        begin
            mem_req.wr_en = 1'b0;
            mem_req.rd_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
        end
        else if (accept)
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            cur_reg       <= cur_next;
        end
    end

endmodule

>>> hdl/ring_fifo_with_peek_cursor.sv
// Top level of the ring FIFO with peek cursor.
// Instantiates rfpc_ctrl and rfpc_ram; uses rfpc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, kind, data_in) carries one request
//   per item: push, pop, start cursor at tail, step cursor forward, step
//   cursor back. Output channel (out_valid / out_stall) returns exactly one
//   result item per request: ok, data_out, count, is_full, is_empty.
//   The result of a request is registered at its accepting edge, read data
//   coming straight from the slot memory's output register. While in_stall
//   is low, requests are taken at one item per cycle: indices, count and cursor
//   update at the accepting edge, and the single memory port does one read
//   or one write per request, so back-to-back requests never collide.
//   A push writes at its accepting edge, so a later read sees the new data.
//   When the receiver stalls, the result holds in the output register and
//   the memory read register; in_stall rises only while a result waits and
//   out_stall is high, and drops in the cycle the result is taken.
//   Reset (rst_n low, asynchronous) empties the buffer, invalidates the
//   cursor and clears out_valid; slot contents are left as they are.
//   Refused requests and pushes return data_out of zero.
module ring_fifo_with_peek_cursor
    import rfpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [DATA_WIDTH-1:0] data_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ok,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [CNT_W-1:0]      count,
    output logic                  is_full,
    output logic                  is_empty
);

    logic     accept;
    mem_req_t mem_req;
    resp_t    resp;
    data_t    rd_data;

    logic out_valid_reg, out_valid_next;
    logic ok_reg;
    cnt_t count_reg;

    // Mark whether the current result came with a memory read.
    logic rd_valid_reg;

    // Hold new requests only while a finished result is stuck.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    rfpc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .mem_req (mem_req),
        .resp    (resp)
    );

    rfpc_ram #(
        .DEPTH (SIZE),
        .WIDTH (DATA_WIDTH)
    ) u_slots (
        .clk   (clk),
        .wr_en (mem_req.wr_en),
        .rd_en (mem_req.rd_en),
        .addr  (mem_req.addr),
        .wdata (data_in),
        .rdata (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture result payload with the request; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= resp.ok;
            count_reg <= resp.count;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    // Push results read nothing: the memory register keeps older data, so
    // gate it with ok and with whether this request issued a read.
    assign data_out  = (ok_reg && rd_valid_reg) ? rd_data : '0;
    assign count     = count_reg;
    assign is_full   = (count_reg == CNT_FULL);
    assign is_empty  = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_valid_reg <= mem_req.rd_en;
        end
    end

endmodule

>>> verif/rfpc_reply_checker.sv
// Reply checker for the ring FIFO with peek cursor: watches both channels,
// predicts each reply from its own copy of the buffer and compares in order.
// Depends on rfpc_pkg for sizes, types and request kinds.
module rfpc_reply_checker
    import rfpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  data_t             data_in,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              ok,
    input  data_t             data_out,
    input  cnt_t              count,
    input  logic              is_full,
    input  logic              is_empty,
    output int                fail_count,
    output int                reply_backlog
);

    typedef struct packed {
        logic  ok;
        data_t data;
        cnt_t  count;
        logic  full;
        logic  empty;
    } reply_t;

    data_t  slot_copy [SIZE];
    idx_t   write_pos;
    idx_t   read_pos;
    idx_t   peek_pos;
    logic   filled_last;
    logic   peek_live;
    reply_t replies_due [$];
    reply_t want;
    reply_t got;
    int     mismatches;

    function automatic idx_t step_up(input idx_t i);
        return (int'(i) == SIZE - 1) ? idx_t'(0) : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t step_down(input idx_t i);
        return (i == '0) ? idx_t'(SIZE - 1) : idx_t'(i - 1'b1);
    endfunction

    function automatic cnt_t entries_held();
        if (write_pos == read_pos)
            return filled_last ? CNT_FULL : cnt_t'(0);
        if (write_pos > read_pos)
            return cnt_t'(int'(write_pos) - int'(read_pos));
        return cnt_t'(int'(write_pos) + SIZE - int'(read_pos));
    endfunction

    // Apply one request to the buffer copy and return the reply it earns.
    function automatic reply_t apply_request(input logic [KIND_W-1:0] req, input data_t value);
        reply_t r;
        logic   at_full;
        logic   at_empty;
        idx_t   nxt;
        r        = '0;
        at_full  = (write_pos == read_pos) && filled_last;
        at_empty = (write_pos == read_pos) && !filled_last;
        case (req)
            KIND_PUSH:
                if (!at_full)
                begin
                    slot_copy[write_pos] = value;
                    write_pos            = step_up(write_pos);
                    filled_last          = 1'b1;
                    r.ok                 = 1'b1;
                end
            KIND_POP:
                if (!at_empty)
                begin
                    r.data      = slot_copy[read_pos];
                    read_pos    = step_up(read_pos);
                    filled_last = 1'b0;
                    r.ok        = 1'b1;
                end
            KIND_START:
                if (!at_empty)
                begin
                    peek_pos  = read_pos;
                    peek_live = 1'b1;
                    r.data    = slot_copy[peek_pos];
                    r.ok      = 1'b1;
                end
            KIND_FWD:
                if (peek_live)
                begin
                    nxt = step_up(peek_pos);
                    if (nxt != write_pos)
                    begin
                        peek_pos = nxt;
                        r.data   = slot_copy[peek_pos];
                        r.ok     = 1'b1;
                    end
                end
            KIND_BACK:
                if (peek_live && peek_pos != read_pos)
                begin
                    peek_pos = step_down(peek_pos);
                    r.data   = slot_copy[peek_pos];
                    r.ok     = 1'b1;
                end
            default:
                ;
        endcase
        r.count = entries_held();
        r.full  = (r.count == CNT_FULL);
        r.empty = (r.count == '0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos   = '0;
            read_pos    = '0;
            peek_pos    = '0;
            filled_last = 1'b0;
            peek_live   = 1'b0;
            mismatches  = 0;
            replies_due.delete();
            fail_count    <= 0;
            reply_backlog <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {ok, data_out, count, is_full, is_empty};
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply with none due: ok=%0b data=%h count=%0d full=%0b empty=%0b",
                                 $time, got.ok, got.data, got.count, got.full, got.empty);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected ok=%0b data=%h count=%0d full=%0b empty=%0b, got ok=%0b data=%h count=%0d full=%0b empty=%0b",
                                     $time, want.ok, want.data, want.count, want.full, want.empty,
                                     got.ok, got.data, got.count, got.full, got.empty);
                    end
                end
            end
            if (in_valid && !in_stall)
                replies_due.push_back(apply_request(kind, data_in));
            fail_count    <= mismatches;
            reply_backlog <= replies_due.size();
        end
    end

endmodule

>>> verif/testbench.sv
// Top of the ring FIFO with peek cursor testbench: clock, reset, request
// stimulus, receiver stalls and the verdict.
// Depends on rfpc_pkg, ring_fifo_with_peek_cursor and rfpc_reply_checker.
module testbench;
    import rfpc_pkg::*;

    localparam int ITEM_TARGET = 550;     // counted random requests
    localparam int CALM_TAIL   = 60;      // last requests run with no idling
    localparam int MAX_IDLE    = 17;      // longest gap or stall burst
    localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              out_stall = 1'b0;
    logic [KIND_W-1:0] kind      = KIND_PUSH;
    data_t             data_in   = '0;
    logic              in_stall;
    logic              out_valid;
    logic              ok;
    data_t             data_out;
    cnt_t              count;
    logic              is_full;
    logic              is_empty;

    int fail_count;
    int reply_backlog;
    int cycles     = 0;
    int stall_left = 0;
    bit idling_on  = 1'b1;

    ring_fifo_with_peek_cursor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .data_out  (data_out),
        .count     (count),
        .is_full   (is_full),
        .is_empty  (is_empty)
    );

    rfpc_reply_checker check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .data_in       (data_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .data_out      (data_out),
        .count         (count),
        .is_full       (is_full),
        .is_empty      (is_empty),
        .fail_count    (fail_count),
        .reply_backlog (reply_backlog)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Give up on a hung run: a lost reply or a stuck stall ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver side: hold off replies in random bursts while idling is on.
    // A burst already under way runs out even after idling is switched off.
    always @(posedge clk)
    begin
        if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, MAX_IDLE);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Offer one request and hold it until the block takes it. An optional
    // gap comes first; valid is only lowered for a gap so that a request
    // following straight on keeps valid high across the edge.
    task automatic send_item(input logic [KIND_W-1:0] req, input data_t value);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, MAX_IDLE);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind     <= req;
        data_in  <= value;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    initial
    begin
        int                i;
        int                u;
        int                sent;
        int                phase_len;
        int                push_pct;
        int                roll;
        logic [KIND_W-1:0] req;
        data_t             fill;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Refusals on a fresh buffer: steps with no cursor yet, pop and
        // cursor start while empty, and every unknown kind.
        send_item(KIND_FWD, '0);
        send_item(KIND_BACK, '1);
        send_item(KIND_POP, '0);
        send_item(KIND_START, '1);
        for (u = KIND_BACK + 1; u < 2 ** KIND_W; u++)
            send_item(u[KIND_W-1:0], $urandom);

        // Fill every slot, with all-zero and all-one data at the front, so
        // that no later cursor step can land on a slot never written.
        for (i = 0; i < SIZE; i++)
        begin
            if (i == 0)
                fill = '0;
            else if (i == 1)
                fill = '1;
            else
                fill = $urandom;
            send_item(KIND_PUSH, fill);
        end
        send_item(KIND_PUSH, $urandom);    // refused: full
        send_item(KIND_START, '0);         // cursor on the oldest entry
        send_item(KIND_BACK, '0);          // refused: cursor sits at tail
        send_item(KIND_FWD, '0);

        // Drain to one entry; the cursor goes stale behind the tail.
        for (i = 0; i < SIZE - 1; i++)
            send_item(KIND_POP, '0);
        send_item(KIND_BACK, '0);          // stale cursor still steps back
        send_item(KIND_START, '0);         // cursor on the last entry
        send_item(KIND_FWD, '0);           // refused: next slot is head
        send_item(KIND_BACK, '0);          // refused: cursor sits at tail
        send_item(KIND_POP, '0);           // now empty
        send_item(KIND_POP, '0);           // refused: empty
        send_item(KIND_FWD, '0);           // refused: stale cursor meets head
        send_item(KIND_PUSH, $urandom);
        send_item(KIND_FWD, '0);           // stale cursor reaches the new entry

        // Random phases: each leans toward filling, draining or hovering,
        // with about a third of requests working the cursor. Unknown kinds
        // are sprinkled in but not counted.
        sent = 0;
        while (sent < ITEM_TARGET)
        begin
            phase_len = $urandom_range(20, 60);
            if (ITEM_TARGET - sent > CALM_TAIL)
            begin
                if (phase_len > ITEM_TARGET - sent - CALM_TAIL)
                    phase_len = ITEM_TARGET - sent - CALM_TAIL;
                idling_on = ($urandom_range(0, 3) != 0);
            end
            else
            begin
                idling_on = 1'b0;
            end
            case ($urandom_range(0, 2))
                0:       push_pct = 20;
                1:       push_pct = 34;
                default: push_pct = 54;
            endcase
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                begin
                    send_item(KIND_W'($urandom_range(KIND_BACK + 1, 2 ** KIND_W - 1)), $urandom);
                end
                else
                begin
                    if (roll < 2 + push_pct)
                        req = KIND_PUSH;
                    else if (roll < 70)
                        req = KIND_POP;
                    else if (roll < 78)
                        req = KIND_START;
                    else if (roll < 90)
                        req = KIND_FWD;
                    else
                        req = KIND_BACK;
                    send_item(req, $urandom);
                    sent++;
                end
            end
        end

        // Drop valid, wait out every reply, then keep the clock running so
        // that a stray extra reply would still be seen.
        in_valid <= 1'b0;
        idling_on = 1'b0;
        do
            @(posedge clk);
        while (reply_backlog != 0);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && reply_backlog == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> ring_fifo_with_peek_cursor.f
hdl/rfpc_pkg.sv
hdl/rfpc_ram.sv
hdl/rfpc_ctrl.sv
hdl/ring_fifo_with_peek_cursor.sv
verif/rfpc_reply_checker.sv
verif/testbench.sv
